// File: src/sfr_pkg.sv
// Shared constants for the stuffed frame receiver: framing symbols,
// frame status codes and counter widths.
// No dependencies.
package sfr_pkg;

  // Longest frame in raw bytes, STX included
  localparam int MaxFrameBytes = 256;

  // Byte index must be able to hold MaxFrameBytes itself
  localparam int IdxW = $clog2(MaxFrameBytes + 1);

  // Declared length is 16 bits; positions derived from it need one more bit
  localparam int LenW = 16;
  localparam int PosW = LenW + 1;

  // Framing symbols
  localparam logic [7:0] SymStart = 8'h02;
  localparam logic [7:0] SymEnd   = 8'h03;
  localparam logic [7:0] SymEsc   = 8'h2F;
  localparam logic [7:0] EscMask  = 8'h7F;

  // Frame status codes carried on the end-of-frame result
  localparam logic [2:0] StatGood     = 3'd0;
  localparam logic [2:0] StatChkBad   = 3'd1;
  localparam logic [2:0] StatLenBad   = 3'd2;
  localparam logic [2:0] StatAborted  = 3'd3;
  localparam logic [2:0] StatOverflow = 3'd4;

endpackage

// File: src/stuffed_frame_receiver.sv
// Latency: a result is valid in the cycle after its byte transfer.
// Throughput: one raw byte per cycle unless stalled; each byte is decoded
// by compares, one XOR and counter updates into a single output register.
// A byte is taken while a result waits, unless that result is stalled.
// Reset (rst_ni low, asynchronous) returns the decoder to idle with all
// frame state cleared and no result pending.
//
// Stuffed frame receiver: STX/ETX framed, byte-stuffed stream decoder.
// Depends on sfr_pkg.
module stuffed_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_end_o,
  output logic [7:0] payload_byte_o,
  output logic [2:0] frame_status_o,
  output logic [7:0] frame_length_o
);
  import sfr_pkg::*;

  // Frame state
  logic            rcv_q, rcv_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      xor_q, xor_d;
  logic            esc_q, esc_d;
  logic [7:0]      chk1_q, chk1_d;
  logic [7:0]      chk_q, chk_d;
  logic [7:0]      cnt_q, cnt_d;

  // Result register
  logic            out_vld_q;
  logic            end_q;
  logic [7:0]      pay_q;
  logic [2:0]      stat_q;
  logic [7:0]      flen_q;

  // Result of the current byte
  logic            res_vld;
  logic            res_end;
  logic [7:0]      res_pay;
  logic [2:0]      res_stat;
  logic [7:0]      res_flen;

  logic            acc;
  logic            out_load;
  logic            clr;
  logic            start;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] len_ext;
  logic [7:0]      pay_val;
  logic            pay_emit;

  // Hold input only while a finished result is stalled
  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !out_load;
  assign acc        = in_valid_i && !in_stall_o;

  assign pos     = PosW'(idx_q);
  assign len_ext = {1'b0, len_q};

  // Decode one byte
  always_comb begin
    rcv_d    = rcv_q;
    idx_d    = idx_q;
    len_d    = len_q;
    xor_d    = xor_q;
    esc_d    = esc_q;
    chk1_d   = chk1_q;
    chk_d    = chk_q;
    cnt_d    = cnt_q;
    res_vld  = 1'b0;
    res_end  = 1'b0;
    res_pay  = 8'h00;
    res_stat = StatGood;
    res_flen = 8'h00;
    clr      = 1'b0;
    start    = 1'b0;
    pay_val  = rx_byte_i;
    pay_emit = 1'b0;

    if (acc) begin
      if (rx_byte_i == SymStart) begin
        // abort any open frame, then open a new one
        if (rcv_q) begin
          res_vld  = 1'b1;
          res_end  = 1'b1;
          res_stat = StatAborted;
          res_flen = cnt_q;
        end
        clr   = 1'b1;
        start = 1'b1;
      end else if (rcv_q) begin
        if (idx_q >= IdxW'(MaxFrameBytes)) begin
          res_vld  = 1'b1;
          res_end  = 1'b1;
          res_stat = StatOverflow;
          res_flen = cnt_q;
          clr      = 1'b1;
        end else if (rx_byte_i == SymEnd) begin
          res_vld  = 1'b1;
          res_end  = 1'b1;
          res_flen = cnt_q;
          if (esc_q || pos != len_ext + PosW'(7)) begin
            res_stat = StatLenBad;
          end else if (xor_q != chk_q) begin
            res_stat = StatChkBad;
          end else begin
            res_stat = StatGood;
          end
          clr = 1'b1;
        end else begin
          idx_d = idx_q + IdxW'(1);
          if (pos <= PosW'(4)) begin
            // length header: one nibble per byte, least significant first
            xor_d = xor_q ^ rx_byte_i;
            case (idx_q[2:0])
              3'd1:    len_d[3:0]   = rx_byte_i[7:4];
              3'd2:    len_d[7:4]   = rx_byte_i[7:4];
              3'd3:    len_d[11:8]  = rx_byte_i[7:4];
              default: len_d[15:12] = rx_byte_i[7:4];
            endcase
          end else if (pos < len_ext + PosW'(5)) begin
            // stuffed data
            xor_d = xor_q ^ rx_byte_i;
            if (esc_q) begin
              esc_d    = 1'b0;
              pay_val  = rx_byte_i & EscMask;
              pay_emit = 1'b1;
            end else if (rx_byte_i == SymEsc) begin
              esc_d = 1'b1;
            end else begin
              pay_emit = 1'b1;
            end
          end else if (pos == len_ext + PosW'(5)) begin
            chk1_d = rx_byte_i;
          end else if (pos == len_ext + PosW'(6)) begin
            chk_d = {rx_byte_i[7:4], chk1_q[7:4]};
          end
        end

        // emit payload, or overflow when the count is saturated
        if (pay_emit) begin
          res_vld = 1'b1;
          if (cnt_q == 8'hFF) begin
            res_end  = 1'b1;
            res_stat = StatOverflow;
            res_flen = cnt_q;
            clr      = 1'b1;
          end else begin
            cnt_d   = cnt_q + 8'd1;
            res_pay = pay_val;
          end
        end
      end
    end

    // clear frame state; a start byte leaves the decoder at position one
    if (clr) begin
      rcv_d  = start;
      idx_d  = start ? IdxW'(1) : '0;
      len_d  = '0;
      xor_d  = '0;
      esc_d  = 1'b0;
      chk1_d = '0;
      chk_d  = '0;
      cnt_d  = '0;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q  <= 1'b0;
      idx_q  <= '0;
      len_q  <= '0;
      xor_q  <= '0;
      esc_q  <= 1'b0;
      chk1_q <= '0;
      chk_q  <= '0;
      cnt_q  <= '0;
    end else begin
      rcv_q  <= rcv_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
      xor_q  <= xor_d;
      esc_q  <= esc_d;
      chk1_q <= chk1_d;
      chk_q  <= chk_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result valid: load whenever the register is free or drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= res_vld;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (out_load && res_vld) begin
      end_q  <= res_end;
      pay_q  <= res_pay;
      stat_q <= res_stat;
      flen_q <= res_flen;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign is_end_o       = end_q;
  assign payload_byte_o = pay_q;
  assign frame_status_o = stat_q;
  assign frame_length_o = flen_q;

endmodule
